@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the disjoint-set engine.
// Depends on nothing; the bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at every rising edge while out of reset.
`define UF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that expr never holds while out of reset.
`define UF_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define UF_ASSERT(label, clk, rst_n, prop, msg)
`define UF_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

@@ hw/rtl/ufph_pkg.sv @@
// Package of the disjoint-set engine: payload structs, operation codes, defaults.
// Depends on nothing.
`default_nettype none
package ufph_pkg;

	localparam int INDEX_W     = 8;
	localparam int KIND_W      = 2;
	localparam int DEF_ENTRIES = 256;
	localparam int LUT_DEPTH   = 1 << INDEX_W;

	localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_UNITE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [INDEX_W-1:0] first_index;
		logic [INDEX_W-1:0] second_index;
	} req_t;

	typedef struct packed {
		logic [INDEX_W-1:0] root;
		logic               joined;
	} rsp_t;

endpackage
`default_nettype wire

@@ hw/rtl/union_find_path_halving.sv @@
// Top level of the disjoint-set engine: parent table memory, walk sequencer, result register.
// Depends on ufph_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Disjoint-set (union-find) engine with path halving. One request is taken at a
// time on req (kind, first_index, second_index); each request yields exactly one
// response on rsp (root, joined). Find walks parent links from first_index to its
// root; on every hop the visited entry is re-pointed at its grandparent. Unite
// finds both roots, links the first root under the second when they differ and
// reports joined; root is always the first root found before linking. Clear makes
// every element a singleton again; the unused kind changes nothing. Both report
// root 0, joined 0. Indices at or above ENTRIES wrap modulo ENTRIES.
// The parent table is one synchronous memory with one read and one write port,
// and each hop needs the entry and then its parent, so a hop passes through the
// NODE state and then the GRAND state. The response sits in its own register,
// so a new request is taken while the last response waits.
// Reset and clear act through one valid bit per entry, so no clearing pass runs.
module union_find_path_halving #(
	parameter int ENTRIES = ufph_pkg::DEF_ENTRIES
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_ready,
	input  wire ufph_pkg::req_t  req_data,
	output logic                 rsp_valid,
	input  wire logic            rsp_ready,
	output ufph_pkg::rsp_t       rsp_data
);

	// Only the first 256 entries are reachable through an 8-bit index.
	localparam int DEPTH = (ENTRIES < ufph_pkg::LUT_DEPTH) ? ENTRIES : ufph_pkg::LUT_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	localparam logic [1:0] ST_IDLE = 2'd0; // ready for a request
	localparam logic [1:0] ST_NODE = 2'd1; // parent of x_q arrives
	localparam logic [1:0] ST_GRAND = 2'd2; // grandparent of x_q arrives
	localparam logic [1:0] ST_DONE = 2'd3; // hand result to response register

	logic [1:0]                  state_q;
	logic [ufph_pkg::KIND_W-1:0] kind_q;
	logic                        second_q;  // walking the second element of a unite
	logic [AW-1:0]               x_q;       // current node of the walk
	logic [AW-1:0]               b_q;       // second element, wrapped
	logic [AW-1:0]               ra_q;      // first root of a unite
	ufph_pkg::rsp_t              res_q;
	ufph_pkg::rsp_t              rsp_q;
	logic                        rsp_valid_q;

	// Parent table and its per-entry valid bits; an invalid entry reads as its own index.
	logic [AW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [AW-1:0]    rd_data_s1;
	logic [AW-1:0]    rd_addr_s1;
	logic             rd_vld_s1;

	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] wr_data;
	logic [AW-1:0] node;
	logic          accept;
	logic          is_walk;
	logic          clear_all;

	// Index wrap table, worked out at elaboration.
	logic [AW-1:0] wrap_lut [ufph_pkg::LUT_DEPTH];
	for (genvar g = 0; g < ufph_pkg::LUT_DEPTH; g++) begin : g_wrap
		localparam int WRAPPED = g % ENTRIES;
		assign wrap_lut[g] = AW'(WRAPPED);
	end

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign is_walk   = (req_data.kind == ufph_pkg::KIND_FIND) ||
		(req_data.kind == ufph_pkg::KIND_UNITE);
	assign clear_all = accept && (req_data.kind == ufph_pkg::KIND_CLEAR);
	assign node      = rd_vld_s1 ? rd_data_s1 : rd_addr_s1;

	// Drive memory ports from the walk state.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = x_q;
		wr_en   = 1'b0;
		wr_addr = x_q;
		wr_data = node;
		case (state_q)
			ST_IDLE: begin
				// Issue the first read right at acceptance.
				rd_en   = accept && is_walk;
				rd_addr = wrap_lut[req_data.first_index];
			end
			ST_NODE: begin
				if (node != x_q) begin
					rd_en   = 1'b1;
					rd_addr = node;
				end else if (kind_q == ufph_pkg::KIND_UNITE && !second_q) begin
					rd_en   = 1'b1;
					rd_addr = b_q;
				end else if (kind_q == ufph_pkg::KIND_UNITE && ra_q != x_q) begin
					// Link first root under second root.
					wr_en   = 1'b1;
					wr_addr = ra_q;
					wr_data = x_q;
				end
			end
			ST_GRAND: begin
				// Halve: point x at its grandparent and move on to it.
				wr_en   = 1'b1;
				rd_en   = 1'b1;
				rd_addr = node;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
			rd_addr_s1 <= rd_addr;
			rd_vld_s1  <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (clear_all) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Walk sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			second_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						second_q <= 1'b0;
						state_q  <= is_walk ? ST_NODE : ST_DONE;
					end
				end
				ST_NODE: begin
					if (node != x_q) begin
						state_q <= ST_GRAND;
					end else if (kind_q == ufph_pkg::KIND_UNITE && !second_q) begin
						second_q <= 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_GRAND: begin
					state_q <= ST_NODE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Walk payload: hold the request and the partial results.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					kind_q <= req_data.kind;
					x_q    <= wrap_lut[req_data.first_index];
					b_q    <= wrap_lut[req_data.second_index];
					res_q  <= '0;
				end
			end
			ST_NODE: begin
				if (node == x_q) begin
					if (kind_q == ufph_pkg::KIND_UNITE && !second_q) begin
						ra_q <= x_q;
						x_q  <= b_q;
					end else if (kind_q == ufph_pkg::KIND_UNITE) begin
						res_q.root   <= ufph_pkg::INDEX_W'(ra_q);
						res_q.joined <= (ra_q != x_q);
					end else begin
						res_q.root   <= ufph_pkg::INDEX_W'(x_q);
						res_q.joined <= 1'b0;
					end
				end
			end
			ST_GRAND: begin
				x_q <= node;
			end
			default: begin
			end
		endcase
	end

	// Response register: load from DONE when empty or being drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// No write ever makes an entry its own parent: halving and linking keep trees acyclic.
	`UF_NEVER(a_no_self_link, clk, arst_n, wr_en && (wr_data == wr_addr), "self link written")
	// Reads and writes in one cycle never touch the same entry.
	`UF_NEVER(a_no_rw_clash, clk, arst_n, wr_en && rd_en && (wr_addr == rd_addr), "rw clash")
	// An accepted request always leaves the sequencer busy in the cycle after it is taken.
	`UF_ASSERT(a_busy_after_accept, clk, arst_n, accept |=> !req_ready, "ready after accept")

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for union_find_path_halving: a stimulus table, then random
// find/unite/clear traffic with and without random idling on both channels, against a shadow parent table.
// Depends on ufph_pkg and the union_find_path_halving RTL.
module tb;

	localparam int TABLE_SIZE = ufph_pkg::DEF_ENTRIES;
	localparam int HOLD_CYCLES = 200;   // long receiver hold-off to back up the block
	localparam int QUIET_LIMIT = 4000;  // worst unite walks two long chains
	localparam int SETTLE_CYCLES = 30;
	localparam logic [ufph_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam logic [ufph_pkg::KIND_W-1:0] K_FIND  = ufph_pkg::KIND_FIND;
	localparam logic [ufph_pkg::KIND_W-1:0] K_UNITE = ufph_pkg::KIND_UNITE;
	localparam logic [ufph_pkg::KIND_W-1:0] K_CLEAR = ufph_pkg::KIND_CLEAR;

	// One row of the directed script. Rows with known set carry a response that can be
	// read straight off the operation; the rest are checked against the shadow table.
	typedef struct packed {
		logic [ufph_pkg::KIND_W-1:0]  kind;
		logic [ufph_pkg::INDEX_W-1:0] first;
		logic [ufph_pkg::INDEX_W-1:0] second;
		logic                         known;
		logic [ufph_pkg::INDEX_W-1:0] root;
		logic                         joined;
	} script_row_t;

	localparam int SCRIPT_ROWS = 25;
	localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
		// fresh table: every element is its own root
		'{K_FIND,      8'd0,   8'd0,   1'b1, 8'd0,   1'b0},
		'{K_FIND,      8'd255, 8'd0,   1'b1, 8'd255, 1'b0},
		'{K_FIND,      8'd170, 8'd85,  1'b1, 8'd170, 1'b0},
		'{K_FIND,      8'd85,  8'd170, 1'b1, 8'd85,  1'b0},
		// extremes joined, then the same pair again in both orders and with itself
		'{K_UNITE,     8'd0,   8'd255, 1'b1, 8'd0,   1'b1},
		'{K_UNITE,     8'd255, 8'd0,   1'b1, 8'd255, 1'b0},
		'{K_FIND,      8'd0,   8'd0,   1'b1, 8'd255, 1'b0},
		'{K_UNITE,     8'd0,   8'd0,   1'b1, 8'd255, 1'b0},
		// unused kind changes nothing
		'{KIND_UNUSED, 8'd170, 8'd85,  1'b1, 8'd0,   1'b0},
		'{K_UNITE,     8'd85,  8'd170, 1'b1, 8'd85,  1'b1},
		// build the chain 1 -> 2 -> 3 -> 4 -> 5 -> 6
		'{K_UNITE,     8'd1,   8'd2,   1'b1, 8'd1,   1'b1},
		'{K_UNITE,     8'd2,   8'd3,   1'b1, 8'd2,   1'b1},
		'{K_UNITE,     8'd3,   8'd4,   1'b1, 8'd3,   1'b1},
		'{K_UNITE,     8'd4,   8'd5,   1'b1, 8'd4,   1'b1},
		'{K_UNITE,     8'd5,   8'd6,   1'b1, 8'd5,   1'b1},
		// walk it and let halving reshape it
		'{K_FIND,      8'd1,   8'd0,   1'b0, 8'd0,   1'b0},
		'{K_FIND,      8'd2,   8'd0,   1'b0, 8'd0,   1'b0},
		'{K_UNITE,     8'd6,   8'd255, 1'b0, 8'd0,   1'b0},
		'{K_FIND,      8'd1,   8'd0,   1'b0, 8'd0,   1'b0},
		'{K_UNITE,     8'd1,   8'd0,   1'b0, 8'd0,   1'b0},
		// clear back to singletons
		'{K_CLEAR,     8'd255, 8'd255, 1'b1, 8'd0,   1'b0},
		'{K_FIND,      8'd1,   8'd0,   1'b1, 8'd1,   1'b0},
		'{K_FIND,      8'd255, 8'd0,   1'b1, 8'd255, 1'b0},
		'{K_UNITE,     8'd255, 8'd254, 1'b1, 8'd255, 1'b1},
		'{KIND_UNUSED, 8'd255, 8'd255, 1'b1, 8'd0,   1'b0}
	};

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	ufph_pkg::req_t req_data;
	logic rsp_valid;
	logic rsp_ready;
	ufph_pkg::rsp_t rsp_data;

	union_find_path_halving dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

	// Shadow copy of the parent table and the responses still owed by the block.
	logic [ufph_pkg::INDEX_W-1:0] parent_shadow [TABLE_SIZE];
	ufph_pkg::rsp_t awaited_responses [$];

	bit gaps_on;       // random idling on both channels
	bit long_hold;     // ask the receiver for one long hold-off
	int mismatches;
	int quiet_cycles;
	int n_find, n_unite, n_joined, n_clear, n_unused, n_checked;

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_shadow();
		for (int i = 0; i < TABLE_SIZE; i++) begin
			parent_shadow[i] = ufph_pkg::INDEX_W'(i);
		end
	endfunction

	// Walk to the root, pointing each visited entry at its grandparent on the way.
	function automatic logic [ufph_pkg::INDEX_W-1:0] halve_to_root(
		logic [ufph_pkg::INDEX_W-1:0] start);
		logic [ufph_pkg::INDEX_W-1:0] x;
		logic [ufph_pkg::INDEX_W-1:0] grand;
		int hops;
		x = ufph_pkg::INDEX_W'(int'(start) % TABLE_SIZE);
		hops = 0;
		while (parent_shadow[x] != x && hops < TABLE_SIZE) begin
			grand = parent_shadow[parent_shadow[x]];
			parent_shadow[x] = grand;
			x = grand;
			hops++;
		end
		return x;
	endfunction

	// Apply one request to the shadow table and return the response it owes.
	function automatic ufph_pkg::rsp_t predict_response(ufph_pkg::req_t r);
		ufph_pkg::rsp_t p;
		logic [ufph_pkg::INDEX_W-1:0] root_a;
		logic [ufph_pkg::INDEX_W-1:0] root_b;
		p = '0;
		case (r.kind)
			K_FIND: begin
				p.root = halve_to_root(r.first_index);
			end
			K_UNITE: begin
				root_a = halve_to_root(r.first_index);
				root_b = halve_to_root(r.second_index);
				p.root = root_a;
				if (root_a != root_b) begin
					parent_shadow[root_a] = root_b;
					p.joined = 1'b1;
				end
			end
			K_CLEAR: begin
				clear_shadow();
			end
			default: begin
			end
		endcase
		return p;
	endfunction

	// Draw a request; indices come from [lo, hi] so that a narrow window builds deep trees.
	function automatic ufph_pkg::req_t random_request(int lo, int hi);
		ufph_pkg::req_t r;
		int pick;
		pick = $urandom_range(99, 0);
		if (pick < 2) begin
			r.kind = K_CLEAR;
		end else if (pick < 4) begin
			r.kind = KIND_UNUSED;
		end else if (pick < 45) begin
			r.kind = K_FIND;
		end else begin
			r.kind = K_UNITE;
		end
		r.first_index = ufph_pkg::INDEX_W'($urandom_range(hi, lo));
		r.second_index = ufph_pkg::INDEX_W'($urandom_range(hi, lo));
		return r;
	endfunction

	// Offer one request and hold it until taken. Valid is lowered only for a real gap,
	// so back-to-back requests never see a low and a high in the same step.
	task automatic offer_request(input ufph_pkg::req_t r, input logic known,
		input ufph_pkg::rsp_t want);
		int gap;
		ufph_pkg::rsp_t predicted;
		gap = gaps_on ? $urandom_range(10, 0) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (!req_ready);
		// taken at this edge: advance the shadow table and log what is owed
		predicted = predict_response(r);
		awaited_responses.insert(awaited_responses.size(), known ? want : predicted);
		case (r.kind)
			K_FIND: n_find++;
			K_UNITE: begin
				n_unite++;
				if (predicted.joined) begin
					n_joined++;
				end
			end
			K_CLEAR: n_clear++;
			default: n_unused++;
		endcase
	endtask

	// Drop valid and wait for every owed response, waiting on the clock even when none is owed.
	task automatic drain_responses();
		req_valid <= 1'b0;
		do @(posedge clk); while (awaited_responses.size() != 0);
	endtask

	// Receiver: random stall before each response, plus one long hold-off on request.
	initial begin
		int stall;
		rsp_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = gaps_on ? $urandom_range(10, 0) : 0;
			if (stall > 0) begin
				rsp_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	// Check every taken response against the oldest owed one.
	always @(posedge clk) begin
		ufph_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			n_checked++;
			if (awaited_responses.size() == 0) begin
				$error("response with nothing owed: root %0d, joined %0d",
					rsp_data.root, rsp_data.joined);
				mismatches++;
			end else begin
				want = awaited_responses.pop_front();
				if (rsp_data.root !== want.root) begin
					$error("root mismatch: expected %0d, actual %0d", want.root, rsp_data.root);
					mismatches++;
				end
				if (rsp_data.joined !== want.joined) begin
					$error("joined mismatch: expected %0d, actual %0d",
						want.joined, rsp_data.joined);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: end the run if neither channel moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no request or response moved for %0d cycles", QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		script_row_t row;
		ufph_pkg::req_t r;
		int base;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		gaps_on = 1'b1;
		long_hold = 1'b0;
		n_find = 0;
		n_unite = 0;
		n_joined = 0;
		n_clear = 0;
		n_unused = 0;
		clear_shadow();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed script.
		for (int i = 0; i < SCRIPT_ROWS; i++) begin
			row = SCRIPT[i];
			r.kind = row.kind;
			r.first_index = row.first;
			r.second_index = row.second;
			offer_request(r, row.known, '{root: row.root, joined: row.joined});
		end
		// Sender pause: hold off until the block has answered everything.
		drain_responses();

		// Random traffic over the whole index range, idling on both sides.
		for (int n = 0; n < 300; n++) begin
			offer_request(random_request(0, 255), 1'b0, '0);
		end

		// Full-rate stretch with no idling at all.
		gaps_on = 1'b0;
		for (int n = 0; n < 100; n++) begin
			offer_request(random_request(0, 255), 1'b0, '0);
		end

		// Back-pressure: receiver holds off while the sender keeps offering.
		long_hold = 1'b1;
		for (int n = 0; n < 40; n++) begin
			offer_request(random_request(0, 63), 1'b0, '0);
		end
		drain_responses();

		// Narrow windows so unites pile up into deep trees and same-set cases.
		gaps_on = 1'b1;
		base = 0;
		for (int n = 0; n < 390; n++) begin
			if (n % 50 == 0) begin
				base = $urandom_range(224, 0);
			end
			offer_request(random_request(base, base + 31), 1'b0, '0);
		end

		drain_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d find, %0d unite (%0d joined), %0d clear, %0d unused",
			n_find + n_unite + n_clear + n_unused, n_find, n_unite, n_joined, n_clear, n_unused);
		$display("Checked %0d responses, %0d mismatches", n_checked, mismatches);
		if (mismatches == 0 && awaited_responses.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end
endmodule
